@@ sv/sia_pkg.sv @@
package sia_pkg;

   localparam int CoordBits = 16;
   localparam int DiffBits  = CoordBits + 1;
   localparam int ProdBits  = 2 * DiffBits;
   localparam int MagBits   = 2 * CoordBits + 1;
   localparam int RemBits   = MagBits + 2;
   localparam int QuoBits   = CoordBits + 1;

   typedef logic signed [CoordBits-1:0] coord_type;

   typedef enum logic [2:0] {
      ST_NONE       = 3'd0,
      ST_PARALLEL   = 3'd1,
      ST_COINCIDENT = 3'd2,
      ST_TIP        = 3'd3,
      ST_CROSS      = 3'd4
   } status_type;

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_end_x;
      coord_type b_end_y;
   } req_type;

   typedef struct packed {
      status_type status;
      coord_type  cross_x;
      coord_type  cross_y;
   } rsp_type;

   // divisor, multiplier-side numerator and |dA| per axis, handed down the row
   typedef struct packed {
      logic [MagBits-1:0] den;
      logic [MagBits-1:0] num;
      logic [QuoBits-1:0] mag_x;
      logic [QuoBits-1:0] mag_y;
   } opnd_type;

   typedef struct packed {
      logic [RemBits-1:0] rem_x;
      logic [QuoBits-1:0] quo_x;
      logic [RemBits-1:0] rem_y;
      logic [QuoBits-1:0] quo_y;
   } div_state_type;

endpackage

@@ sv/sia_cell.sv @@
module sia_cell
   import sia_pkg::*;
#(
   parameter int BitPos = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          valid_in,
   input  opnd_type      opnd_in,
   input  div_state_type div_in,
   output logic          valid_out,
   output opnd_type      opnd_out,
   output div_state_type div_out
);

   // one multiplier bit of num*|d|/den: remainder stays below den, digit 0..2
   function automatic logic [RemBits+QuoBits-1:0] step(
      input logic [RemBits-1:0] rem,
      input logic [QuoBits-1:0] quo,
      input logic [MagBits-1:0] den,
      input logic [MagBits-1:0] num,
      input logic               take
   );
      logic [RemBits-1:0] t;
      logic [RemBits-1:0] d1;
      logic [RemBits-1:0] d2;
      logic [1:0]         k;
      t  = {rem[RemBits-2:0], 1'b0} + (take ? {2'b00, num} : {RemBits{1'b0}});
      d1 = {2'b00, den};
      d2 = {1'b0, den, 1'b0};
      if (t >= d2) begin
         t = t - d2;
         k = 2'd2;
      end else if (t >= d1) begin
         t = t - d1;
         k = 2'd1;
      end else begin
         k = 2'd0;
      end
      return {t, {quo[QuoBits-2:0], 1'b0} + {{(QuoBits-2){1'b0}}, k}};
   endfunction

   logic          valid_ff;
   opnd_type      opnd_ff;
   div_state_type div_ff;
   div_state_type div_in_nxt;

   always_comb begin
      {div_in_nxt.rem_x, div_in_nxt.quo_x} = step(div_in.rem_x, div_in.quo_x,
         opnd_in.den, opnd_in.num, opnd_in.mag_x[BitPos]);
      {div_in_nxt.rem_y, div_in_nxt.quo_y} = step(div_in.rem_y, div_in.quo_y,
         opnd_in.den, opnd_in.num, opnd_in.mag_y[BitPos]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      opnd_ff <= opnd_in;
      div_ff  <= div_in_nxt;
   end

   assign valid_out = valid_ff;
   assign opnd_out  = opnd_ff;
   assign div_out   = div_ff;

endmodule

@@ sv/segment_intersection_unit.sv @@
// Segment intersection unit.
// Input channel: drive both segments on req_data and raise start; a beat is
// taken at every edge where start is high and busy is low. busy is always
// low, so a new segment pair can be offered in every cycle.
// Result channel: one beat per input beat, shown on rsp_data for a single
// cycle with rsp_valid high, in input order. The receiver cannot stall;
// it must take each beat in the cycle it appears.
// The pipeline is a difference stage, a product stage, a numerator stage,
// a sign/range stage, a row of CoordBits+1 divide cells (one multiplier
// bit each, both axes in the same cell) and an output stage. Throughput is
// one pair per cycle, set by the row of cells, each of which takes a new
// operand every cycle.
// status 4 gives the point truncated toward zero; otherwise the point is 0.
// Synchronous reset empties the pipeline; beats in flight are dropped and
// no result beat appears until a new one is taken.
module segment_intersection_unit
   import sia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int NumCells = QuoBits;

   typedef logic signed [DiffBits-1:0] diff_type;
   typedef logic signed [ProdBits-1:0] prod_type;

   typedef struct packed {
      req_type    req;
      status_type pre;
   } ctx_type;

   // stage 1: differences
   logic     v1_ff;
   req_type  req1_ff;
   diff_type dax1_ff, day1_ff, dbx1_ff, dby1_ff, ex1_ff, ey1_ff;
   // stage 2: products
   logic     v2_ff;
   req_type  req2_ff;
   diff_type dax2_ff, day2_ff;
   prod_type p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   // stage 3: denominator and numerators
   logic     v3_ff;
   req_type  req3_ff;
   diff_type dax3_ff, day3_ff;
   prod_type den3_ff, na3_ff, nb3_ff;
   // stage 4: normalised operands
   logic     v4_ff;
   opnd_type opnd4_ff;
   ctx_type  ctx4_ff;

   prod_type   den_n, na_n, nb_n;
   logic       in_range;
   status_type pre_in;

   logic          cell_valid [NumCells+1];
   opnd_type      cell_opnd  [NumCells+1];
   div_state_type cell_div   [NumCells+1];
   ctx_type       ctx_ff     [NumCells];

   logic    out_valid_ff;
   rsp_type out_ff;
   rsp_type out_in;

   always_comb begin
      den_n    = den3_ff[ProdBits-1] ? -den3_ff : den3_ff;
      na_n     = den3_ff[ProdBits-1] ? -na3_ff  : na3_ff;
      nb_n     = den3_ff[ProdBits-1] ? -nb3_ff  : nb3_ff;
      in_range = !na_n[ProdBits-1] && !nb_n[ProdBits-1] && (na_n <= den_n)
                 && (nb_n <= den_n);
      if (den3_ff == '0) begin
         pre_in = (na3_ff == '0 && nb3_ff == '0) ? ST_COINCIDENT : ST_PARALLEL;
      end else if (in_range) begin
         pre_in = ST_CROSS;
      end else begin
         pre_in = ST_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      req1_ff <= req_data;
      dax1_ff <= DiffBits'(req_data.a_end_x) - DiffBits'(req_data.a_start_x);
      day1_ff <= DiffBits'(req_data.a_end_y) - DiffBits'(req_data.a_start_y);
      dbx1_ff <= DiffBits'(req_data.b_end_x) - DiffBits'(req_data.b_start_x);
      dby1_ff <= DiffBits'(req_data.b_end_y) - DiffBits'(req_data.b_start_y);
      ex1_ff  <= DiffBits'(req_data.a_start_x) - DiffBits'(req_data.b_start_x);
      ey1_ff  <= DiffBits'(req_data.a_start_y) - DiffBits'(req_data.b_start_y);

      req2_ff <= req1_ff;
      dax2_ff <= dax1_ff;
      day2_ff <= day1_ff;
      p0_ff   <= dby1_ff * dax1_ff;
      p1_ff   <= dbx1_ff * day1_ff;
      p2_ff   <= dbx1_ff * ey1_ff;
      p3_ff   <= dby1_ff * ex1_ff;
      p4_ff   <= dax1_ff * ey1_ff;
      p5_ff   <= day1_ff * ex1_ff;

      req3_ff <= req2_ff;
      dax3_ff <= dax2_ff;
      day3_ff <= day2_ff;
      den3_ff <= p0_ff - p1_ff;
      na3_ff  <= p2_ff - p3_ff;
      nb3_ff  <= p4_ff - p5_ff;

      opnd4_ff.den   <= den_n[MagBits-1:0];
      opnd4_ff.num   <= na_n[MagBits-1:0];
      opnd4_ff.mag_x <= dax3_ff[DiffBits-1] ? QuoBits'(-dax3_ff) : QuoBits'(dax3_ff);
      opnd4_ff.mag_y <= day3_ff[DiffBits-1] ? QuoBits'(-day3_ff) : QuoBits'(day3_ff);
      ctx4_ff.req    <= req3_ff;
      ctx4_ff.pre    <= pre_in;
   end

   assign cell_valid[0] = v4_ff;
   assign cell_opnd[0]  = opnd4_ff;
   assign cell_div[0]   = '0;

   for (genvar i = 0; i < NumCells; i++) begin : g_row
      sia_cell #(
         .BitPos(NumCells - 1 - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .valid_in (cell_valid[i]),
         .opnd_in  (cell_opnd[i]),
         .div_in   (cell_div[i]),
         .valid_out(cell_valid[i+1]),
         .opnd_out (cell_opnd[i+1]),
         .div_out  (cell_div[i+1])
      );

      always_ff @(posedge clock) begin
         if (i == 0) begin
            ctx_ff[i] <= ctx4_ff;
         end else begin
            ctx_ff[i] <= ctx_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   // start +/- quotient, stepped one toward zero when a fraction is left
   function automatic coord_type fix_point(
      input coord_type          base,
      input logic               neg,
      input logic [QuoBits-1:0] quo,
      input logic               frac
   );
      logic signed [CoordBits+1:0] b;
      logic signed [CoordBits+1:0] q;
      logic signed [CoordBits+1:0] s;
      b = (CoordBits+2)'(base);
      q = {1'b0, quo};
      if (!neg) begin
         s = b + q;
         if (s[CoordBits+1] && frac) begin
            s = s + {{(CoordBits+1){1'b0}}, 1'b1};
         end
      end else begin
         s = b - q;
         if (!s[CoordBits+1] && (s != '0) && frac) begin
            s = s - {{(CoordBits+1){1'b0}}, 1'b1};
         end
      end
      return s[CoordBits-1:0];
   endfunction

   always_comb begin
      ctx_type       c;
      div_state_type d;
      coord_type     ix, iy;
      logic          on_a, on_b;
      c    = ctx_ff[NumCells-1];
      d    = cell_div[NumCells];
      ix   = fix_point(c.req.a_start_x, c.req.a_end_x < c.req.a_start_x, d.quo_x,
                       d.rem_x != '0);
      iy   = fix_point(c.req.a_start_y, c.req.a_end_y < c.req.a_start_y, d.quo_y,
                       d.rem_y != '0);
      on_a = (ix == c.req.a_start_x && iy == c.req.a_start_y)
             || (ix == c.req.a_end_x && iy == c.req.a_end_y);
      on_b = (ix == c.req.b_start_x && iy == c.req.b_start_y)
             || (ix == c.req.b_end_x && iy == c.req.b_end_y);
      out_in.status  = c.pre;
      out_in.cross_x = '0;
      out_in.cross_y = '0;
      if (c.pre == ST_CROSS) begin
         if (on_a && on_b) begin
            out_in.status = ST_TIP;
         end else begin
            out_in.cross_x = ix;
            out_in.cross_y = iy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= cell_valid[NumCells];
      end
      out_ff <= out_in;
   end

   assign busy      = 1'b0;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ bench/segment_intersection_unit_tb.sv @@
module segment_intersection_unit_tb
   import sia_pkg::*;
();

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type pending_points[$];
   int      mismatch_count;
   int      cycle_count;
   bit      timed_out;
   int      beats_sent;

   localparam int Latency    = 22;
   localparam int CycleLimit = 400000;

   segment_intersection_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // exact rational arithmetic; products fit well within 128 bits
   function automatic bit in_range(logic signed [127:0] n, logic signed [127:0] d);
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      return (n >= 0) && (n <= d);
   endfunction

   function automatic rsp_type predict_crossing(req_type r);
      logic signed [127:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      logic signed [127:0] dax, day, dbx, dby, ex, ey, den, na, nb, px, py;
      logic signed [127:0] qx, qy;
      rsp_type res;
      bit on_a, on_b;
      ax0 = r.a_start_x; ay0 = r.a_start_y; ax1 = r.a_end_x; ay1 = r.a_end_y;
      bx0 = r.b_start_x; by0 = r.b_start_y; bx1 = r.b_end_x; by1 = r.b_end_y;
      dax = ax1 - ax0; day = ay1 - ay0; dbx = bx1 - bx0; dby = by1 - by0;
      ex = ax0 - bx0; ey = ay0 - by0;
      den = dby * dax - dbx * day;
      na = dbx * ey - dby * ex;
      nb = dax * ey - day * ex;
      res.status  = ST_NONE;
      res.cross_x = '0;
      res.cross_y = '0;
      if (den == 0) begin
         res.status = (na == 0 && nb == 0) ? ST_COINCIDENT : ST_PARALLEL;
      end else if (in_range(na, den) && in_range(nb, den)) begin
         px = ax0 * den + na * dax;
         py = ay0 * den + na * day;
         qx = px / den;
         qy = py / den;
         on_a = (qx == ax0 && qy == ay0) || (qx == ax1 && qy == ay1);
         on_b = (qx == bx0 && qy == by0) || (qx == bx1 && qy == by1);
         if (on_a && on_b) begin
            res.status = ST_TIP;
         end else begin
            res.status  = ST_CROSS;
            res.cross_x = qx[15:0];
            res.cross_y = qy[15:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("unexpected result beat: %p", rsp_data);
         end else begin
            if (rsp_data !== pending_points[0]) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("mismatch: expected %p, got %p", pending_points[0], rsp_data);
            end
            void'(pending_points.pop_front());
         end
      end
   end

   // keeps start high across back-to-back beats
   task automatic send_pair(req_type r, bit keep_going);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_points.push_back(predict_crossing(r));
      beats_sent++;
      if (!keep_going) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic pair_of(int x0, int y0, int x1, int y1,
                          int u0, int v0, int u1, int v1);
      req_type r;
      r = {16'(x0), 16'(y0), 16'(x1), 16'(y1), 16'(u0), 16'(v0), 16'(u1), 16'(v1)};
      send_pair(r, 1'b0);
   endtask

   task automatic drain_results();
      while (pending_points.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      pair_of(0, 0, 10, 10, 0, 10, 10, 0);
      pair_of(0, 0, 10, 0, 0, 5, 10, 5);
      pair_of(0, 0, 10, 0, 2, 0, 20, 0);
      pair_of(0, 0, 10, 0, 20, 0, 30, 0);
      pair_of(0, 0, 10, 10, 10, 10, 20, 0);
      pair_of(0, 0, 10, 0, 20, -5, 20, 5);
      pair_of(0, 0, 10, 0, 5, 0, 5, 10);
      pair_of(3, 3, 3, 3, 0, 0, 5, 5);
      pair_of(3, 3, 3, 3, 3, 3, 3, 3);
      pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      pair_of(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
      pair_of(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
      pair_of(0, 0, 7, 3, 0, 3, 7, 0);
      pair_of(0, 0, -7, -3, 0, -3, -7, 0);
      pair_of(-32768, -32768, -32768, 32767, -32768, 0, 32767, 0);
      pair_of(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
      pair_of(0, 0, 1, 0, 1, 0, 1, 1);
      pair_of(-1, -1, 1, 1, -1, 1, 1, -1);
      pair_of(32767, 32767, 32767, 32767, 0, 0, 1, 1);
      drain_results();
   endtask

   function automatic logic [15:0] rand_coord(int spread);
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         default: return 16'($signed($urandom_range(0, 2 * spread)) - spread);
      endcase
   endfunction

   task automatic test_random(int count);
      req_type r;
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && sent < count; i++) begin
            r = {rand_coord(20), rand_coord(20), rand_coord(20), rand_coord(20),
                 rand_coord(20), rand_coord(20), rand_coord(20), rand_coord(20)};
            if ($urandom_range(0, 7) == 0) begin
               r.b_start_x = r.a_start_x;
               r.b_start_y = r.a_start_y;
            end else if ($urandom_range(0, 7) == 0) begin
               r.b_end_x = r.a_end_x + (r.a_end_x - r.a_start_x);
               r.b_end_y = r.a_end_y + (r.a_end_y - r.a_start_y);
               r.b_start_x = r.a_start_x;
               r.b_start_y = r.a_start_y + 16'd1;
            end
            sent++;
            send_pair(r, (i + 1 < burst) && (sent < count));
         end
         if ($urandom_range(0, 1)) repeat ($urandom_range(1, 30)) @(posedge clock);
         if (sent > count / 2 && sent - burst <= count / 2) drain_results();
      end
   endtask

   initial begin
      mismatch_count = 0;
      cycle_count    = 0;
      beats_sent     = 0;
      timed_out      = 1'b0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1100);
      drain_results();
      repeat (Latency + 5) @(posedge clock);
      if (mismatch_count == 0 && !timed_out)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("Verification failed");
      $finish;
   end

endmodule
